/* rtl/pcmsw_pkg.sv */
// Package with the shared constants, types and state codes of the mean-square window block.
package pcmsw_pkg;

  localparam int MAX_CHANNELS = 256;
  localparam int CH_AW        = $clog2(MAX_CHANNELS);

  localparam int CHAN_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 32;
  localparam int SUM_W    = 48;
  localparam int MAG_W    = 17;
  localparam int SQ_W     = 31;

  localparam int NCH_W    = 9;
  localparam int SWEEP_W  = 16;
  localparam int INV_W    = 32;
  localparam int SPAN_W   = NCH_W + SWEEP_W;
  localparam int COUNT_W  = 32;
  localparam int STEP_W   = $clog2(COUNT_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE  = 2'd2;

  localparam logic [NCH_W-1:0]   RST_CHANNELS = 9'd256;
  localparam logic [SWEEP_W-1:0] RST_SWEEPS   = 16'd1000;
  localparam logic [INV_W-1:0]   RST_INVERSE  = 32'd4294967;
  localparam logic [SPAN_W-1:0]  RST_SPAN     = 25'd256000;

  localparam logic [MEAN_W-1:0] MEAN_ONE = 32'd16777216;
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [MEAN_W-1:0] mean;
  } entry_t;

  localparam int ENTRY_W = SUM_W + MEAN_W;

  typedef struct packed {
    logic busy;
    logic store;
  } win_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_SCALE,
    ST_WB
  } top_state_t;

  typedef enum logic [1:0] {
    WIN_RUN,
    WIN_SPAN,
    WIN_DIV
  } win_state_t;

  typedef enum logic [1:0] {
    SCL_IDLE,
    SCL_LO,
    SCL_HI,
    SCL_ADD
  } scl_state_t;

endpackage

/* rtl/pcmsw_ifs.sv */
// Channel interfaces for samples, results and configuration writes.
interface pcmsw_in_if import pcmsw_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CHAN_W-1:0]          channel;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

interface pcmsw_out_if import pcmsw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_square;

  modport source (output valid, output mean_square, input ready);
  modport sink (input valid, input mean_square, output ready);
endinterface

interface pcmsw_cfg_if import pcmsw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/pcmsw_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module pcmsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* rtl/pcmsw_window.sv */
// Configuration registers, call counter, window phase and phase recompute divider.
module pcmsw_window import pcmsw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step,
  output win_status_t           status,
  output logic [INV_W-1:0]      inverse
);

  win_state_t          state_r, state_nxt;
  logic [NCH_W-1:0]    nch_r;
  logic [SWEEP_W-1:0]  sweeps_r;
  logic [INV_W-1:0]    inv_r;
  logic [SPAN_W-1:0]   span_r, span_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [SPAN_W-1:0]   phase_r, phase_nxt;
  logic [SPAN_W-1:0]   rem_r, rem_nxt;
  logic [COUNT_W-1:0]  shift_r, shift_nxt;
  logic [STEP_W-1:0]   bit_r, bit_nxt;

  logic [NCH_W-1:0]    n_eff;
  logic [SWEEP_W-1:0]  w_eff;
  logic [SPAN_W-1:0]   n_span;
  logic [COUNT_W-1:0]  n_count;
  logic [COUNT_W-1:0]  cnt_a;
  logic [SPAN_W-1:0]   ph_a;
  logic [SPAN_W:0]     ph_inc;
  logic [SPAN_W:0]     trial;

  assign n_eff   = (nch_r == '0) ? NCH_W'(1) : nch_r;
  assign w_eff   = (sweeps_r == '0) ? SWEEP_W'(1) : sweeps_r;
  assign n_span  = SPAN_W'(n_eff);
  assign n_count = COUNT_W'(n_eff);

  assign status.busy  = (state_r != WIN_RUN);
  assign status.store = (phase_r < n_span) && (count_r >= n_count);
  assign inverse      = inv_r;

  // At the window restart point the counter falls back to the channel count.
  assign cnt_a  = (phase_r == n_span) ? n_count : count_r;
  assign ph_a   = (phase_r == n_span) ? n_span : phase_r;
  assign ph_inc = {1'b0, ph_a} + (SPAN_W+1)'(1);
  assign trial  = {rem_r, shift_r[COUNT_W-1]};

  always_comb begin
    state_nxt = state_r;
    span_nxt  = span_r;
    count_nxt = count_r;
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    shift_nxt = shift_r;
    bit_nxt   = bit_r;
    case (state_r)
      WIN_RUN: begin
        if (step) begin
          count_nxt = cnt_a + COUNT_W'(1);
          if (cnt_a == {COUNT_W{1'b1}}) begin
            phase_nxt = '0;
          end else if (ph_inc == {1'b0, span_r}) begin
            phase_nxt = '0;
          end else begin
            phase_nxt = ph_inc[SPAN_W-1:0];
          end
        end
      end
      WIN_SPAN: begin
        span_nxt  = SPAN_W'(w_eff * n_eff);
        rem_nxt   = '0;
        shift_nxt = count_r;
        bit_nxt   = '0;
        state_nxt = WIN_DIV;
      end
      WIN_DIV: begin
        // Restoring remainder, one counter bit per cycle, most significant first.
        if (trial >= {1'b0, span_r}) begin
          rem_nxt = SPAN_W'(trial - {1'b0, span_r});
        end else begin
          rem_nxt = trial[SPAN_W-1:0];
        end
        shift_nxt = {shift_r[COUNT_W-2:0], 1'b0};
        bit_nxt   = bit_r + STEP_W'(1);
        if (bit_r == STEP_W'(COUNT_W - 1)) begin
          phase_nxt = rem_nxt;
          state_nxt = WIN_RUN;
        end
      end
      default: begin
        state_nxt = WIN_RUN;
      end
    endcase
    if (cfg_we) begin
      state_nxt = WIN_SPAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= WIN_RUN;
      nch_r    <= RST_CHANNELS;
      sweeps_r <= RST_SWEEPS;
      inv_r    <= RST_INVERSE;
      span_r   <= RST_SPAN;
      count_r  <= '0;
      phase_r  <= '0;
    end else begin
      state_r <= state_nxt;
      span_r  <= span_nxt;
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHANNELS: nch_r    <= cfg_data[NCH_W-1:0];
          CFG_SWEEPS:   sweeps_r <= cfg_data[SWEEP_W-1:0];
          CFG_INVERSE:  inv_r    <= cfg_data[INV_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    shift_r <= shift_nxt;
    bit_r   <= bit_nxt;
  end

endmodule

/* rtl/pcmsw_scale.sv */
// Sum times reciprocal with round-half-up and saturation, on one shared 32x32 multiplier.
module pcmsw_scale import pcmsw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  sum,
  input  logic [INV_W-1:0]  inv,
  output logic              done_r,
  output logic [MEAN_W-1:0] result_r
);

  scl_state_t               state_r, state_nxt;
  logic [SUM_W-1:0]         sum_r;
  logic [INV_W-1:0]         inv_r;
  logic [2*INV_W-1:0]       lo_r;
  logic [SUM_W-1:0]         hi_r;
  logic [INV_W-1:0]         mul_a;
  logic [2*INV_W-1:0]       mul_p;
  logic [2*INV_W:0]         lo_round;
  logic [SUM_W:0]           total;

  assign mul_a    = (state_r == SCL_HI) ? INV_W'(sum_r[SUM_W-1:INV_W]) : sum_r[INV_W-1:0];
  assign mul_p    = mul_a * inv_r;
  assign lo_round = {1'b0, lo_r} + (2*INV_W+1)'(64'h8000_0000);
  assign total    = {1'b0, hi_r} + (SUM_W+1)'(lo_round[2*INV_W:INV_W]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SCL_IDLE: if (start) state_nxt = SCL_LO;
      SCL_LO:   state_nxt = SCL_HI;
      SCL_HI:   state_nxt = SCL_ADD;
      SCL_ADD:  state_nxt = SCL_IDLE;
      default:  state_nxt = SCL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SCL_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == SCL_ADD);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == SCL_IDLE && start) begin
      sum_r <= sum;
      inv_r <= inv;
    end
    if (state_r == SCL_LO) begin
      lo_r <= mul_p;
    end
    if (state_r == SCL_HI) begin
      hi_r <= SUM_W'(mul_p);
    end
    if (state_r == SCL_ADD) begin
      if (total > (SUM_W+1)'({MEAN_W{1'b1}})) begin
        result_r <= {MEAN_W{1'b1}};
      end else begin
        result_r <= total[MEAN_W-1:0];
      end
    end
  end

endmodule

/* rtl/per_channel_mean_square_window_core.sv */
// Top level of the per-channel windowed mean-square estimator.
//
//   Channel | Direction | Payload                          | Beat when
//   in_bus  | sink      | channel[7:0], sample[15:0] s     | valid && ready
//   out_bus | source    | mean_square[31:0]                | valid && ready
//   cfg_bus | sink      | index[1:0], data[31:0]           | valid && ready
//
// An ordinary sample beat issues the read of the channel's entry in the beat cycle;
// then ST_SUM adds the square and writes the entry back. A sample that closes a
// window for its channel goes on to ST_SCALE, where the shared 32x32 multiplier in
// the scale unit takes two passes (SCL_LO, SCL_HI) before SCL_ADD, and then to ST_WB.
// After a configuration write the window phase is recomputed by a 32-step remainder
// unit, during which in_bus.ready is low. Reset is synchronous and needs no clearing
// pass: per-entry valid bits make unwritten entries read as their reset.
// A result waiting in the output register does not stop the next sample beat; the
// write-back cycle waits until the output register is free.
module per_channel_mean_square_window_core import pcmsw_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  pcmsw_in_if.sink     in_bus,
  pcmsw_out_if.source  out_bus,
  pcmsw_cfg_if.sink    cfg_bus
);

  top_state_t               state_r, state_nxt;
  logic [CH_AW-1:0]         ch_r;
  logic [SQ_W-1:0]          sq_r;
  logic [MAX_CHANNELS-1:0]  vld_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [MEAN_W-1:0]        out_mean_r, out_mean_nxt;

  logic                     accept_in;
  logic                     cfg_we;
  logic                     out_free;
  logic [CH_AW-1:0]         in_ch;
  logic [CH_AW-1:0]         raddr;
  logic [ENTRY_W-1:0]       rdata;
  entry_t                   old_entry;
  entry_t                   wr_entry;
  logic                     we;
  logic [MAG_W-1:0]         mag;
  logic [2*MAG_W-1:0]       sq_full;
  logic [SUM_W:0]           sum_wide;
  logic [SUM_W-1:0]         new_sum;
  logic                     step;
  logic                     scl_start;
  logic                     scl_done;
  logic [MEAN_W-1:0]        scl_result;
  logic [INV_W-1:0]         inverse;
  win_status_t              win_st;

  // Channel indices beyond the table wrap onto it.
  assign in_ch     = in_bus.channel[CH_AW-1:0];
  assign cfg_bus.ready = (state_r == ST_IDLE);
  assign cfg_we    = cfg_bus.valid && cfg_bus.ready;
  assign in_bus.ready = (state_r == ST_IDLE) && !win_st.busy && !cfg_bus.valid;
  assign accept_in = in_bus.valid && in_bus.ready;
  assign out_free  = !out_valid_r || out_bus.ready;

  assign out_bus.valid       = out_valid_r;
  assign out_bus.mean_square = out_mean_r;

  // Magnitude of the two's complement sample; the most negative code gives 32768.
  assign mag     = in_bus.sample[SAMPLE_W-1] ?
                   MAG_W'(-$signed({in_bus.sample[SAMPLE_W-1], in_bus.sample})) :
                   MAG_W'(in_bus.sample);
  assign sq_full = mag * mag;

  // The address is held on the current channel so the read data stays put while
  // the write-back waits on the output side.
  assign raddr = accept_in ? in_ch : ch_r;

  pcmsw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CHANNELS)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (ch_r),
    .wdata   (wr_entry),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // An entry never written since reset reads as an empty sum and a mean of one.
  always_comb begin
    if (vld_r[ch_r]) begin
      old_entry = entry_t'(rdata);
    end else begin
      old_entry.sum  = '0;
      old_entry.mean = MEAN_ONE;
    end
  end

  assign sum_wide = {1'b0, old_entry.sum} + (SUM_W+1)'(sq_r);
  assign new_sum  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

  pcmsw_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_bus.index),
    .cfg_data  (cfg_bus.data),
    .step      (step),
    .status    (win_st),
    .inverse   (inverse)
  );

  pcmsw_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scl_start),
    .sum      (new_sum),
    .inv      (inverse),
    .done_r   (scl_done),
    .result_r (scl_result)
  );

  always_comb begin
    state_nxt     = state_r;
    we            = 1'b0;
    wr_entry      = old_entry;
    step          = 1'b0;
    scl_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_mean_nxt  = out_mean_r;
    case (state_r)
      ST_IDLE: begin
        if (accept_in) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (win_st.store) begin
          // The window just closed for this channel: scale the sum into a new mean.
          scl_start = 1'b1;
          state_nxt = ST_SCALE;
        end else if (out_free) begin
          we            = 1'b1;
          wr_entry.sum  = new_sum;
          wr_entry.mean = old_entry.mean;
          step          = 1'b1;
          out_valid_nxt = 1'b1;
          out_mean_nxt  = old_entry.mean;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCALE: begin
        if (scl_done) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          we            = 1'b1;
          wr_entry.sum  = '0;
          wr_entry.mean = scl_result;
          step          = 1'b1;
          out_valid_nxt = 1'b1;
          out_mean_nxt  = scl_result;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (we) begin
        vld_r[ch_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_mean_r <= out_mean_nxt;
    if (accept_in) begin
      ch_r <= in_ch;
      sq_r <= sq_full[SQ_W-1:0];
    end
  end

endmodule

/* verif/per_channel_mean_square_window_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the per-channel windowed mean-square estimator core.
module per_channel_mean_square_window_core_tb import pcmsw_pkg::*; ();

  // Register index that decodes to no register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [SAMPLE_W-1:0] MOST_NEGATIVE = 16'h8000;
  localparam logic [SAMPLE_W-1:0] MOST_POSITIVE = 16'h7FFF;

  // A window-closing beat, write-back included, is done well within these quiet
  // cycles after the last result, so they leave the core fully idle.
  localparam int SETTLE_CYCLES = 10;

  // Keeps a runaway mismatch from flooding the log; later mismatches still fail.
  localparam int REPORT_LIMIT = 40;

  // Tracks the configuration, per-channel sums and stored means, and the call
  // counter, and queues the mean square that each accepted sample should return.
  class mean_square_tracker;
    logic [NCH_W-1:0]   chans;
    logic [SWEEP_W-1:0] sweeps;
    logic [INV_W-1:0]   inverse;
    logic [SUM_W-1:0]   sums [MAX_CHANNELS];
    logic [MEAN_W-1:0]  means [MAX_CHANNELS];
    logic [COUNT_W-1:0] calls;
    logic [MEAN_W-1:0]  expected_means [$];
    int unsigned        failures;

    function new();
      chans   = RST_CHANNELS;
      sweeps  = RST_SWEEPS;
      inverse = RST_INVERSE;
      foreach (sums[i]) begin
        sums[i]  = '0;
        means[i] = MEAN_ONE;
      end
      calls    = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHANNELS: chans = data[NCH_W-1:0];
        CFG_SWEEPS: sweeps = data[SWEEP_W-1:0];
        CFG_INVERSE: inverse = data[INV_W-1:0];
        default: ;
      endcase
    endfunction

    // Q24.24 sum times the Q0.32 reciprocal, rounded half up into Q8.24 and
    // clamped to the all-ones mean.
    function logic [MEAN_W-1:0] scale_to_mean(logic [SUM_W-1:0] sum);
      logic [SUM_W+INV_W-1:0] product;
      product = sum * inverse + 32'h8000_0000;
      if (|product[SUM_W+INV_W-1:INV_W+MEAN_W]) return '1;
      return product[INV_W+MEAN_W-1:INV_W];
    endfunction

    function void note_sample(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
      logic [MAG_W-1:0]   mag;
      logic [SUM_W-1:0]   square;
      logic [NCH_W-1:0]   lanes;
      logic [SWEEP_W-1:0] depth;
      logic [COUNT_W-1:0] span;
      logic [COUNT_W-1:0] phase;
      int unsigned        slot;
      slot = ch % MAX_CHANNELS;
      mag = {smp[SAMPLE_W-1], smp};
      if (smp[SAMPLE_W-1]) mag = -mag;
      square = mag * mag;
      if (sums[slot] > SUM_MAX - square) sums[slot] = SUM_MAX;
      else sums[slot] = sums[slot] + square;

      // A zero channel count or zero window behaves as one.
      lanes = (chans == 0) ? 9'd1 : chans;
      depth = (sweeps == 0) ? 16'd1 : sweeps;
      span  = lanes * depth;
      phase = calls % span;
      if (phase < lanes && calls >= lanes) begin
        means[slot] = scale_to_mean(sums[slot]);
        sums[slot]  = '0;
      end
      if (phase == lanes) calls = lanes;
      calls = calls + 1'b1;
      expected_means.push_back(means[slot]);
    endfunction

    function void check_mean(logic [MEAN_W-1:0] actual);
      logic [MEAN_W-1:0] want;
      if (expected_means.size() == 0) begin
        if (failures < REPORT_LIMIT)
          $error("mean_square: expected no beat, actual %0d", actual);
        failures++;
        return;
      end
      want = expected_means.pop_front();
      if (actual !== want) begin
        if (failures < REPORT_LIMIT)
          $error("mean_square: expected %0d, actual %0d", want, actual);
        failures++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_means.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm = 1'b0;

  mean_square_tracker board;

  pcmsw_in_if  in_bus ();
  pcmsw_out_if out_bus ();
  pcmsw_cfg_if cfg_bus ();

  per_channel_mean_square_window_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The result side drops ready at random about 15 percent of the time, except while the
  // run is calm, when ready stays high and it takes a beat whenever one is offered.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // Every beat is observed on the clock edge that completes it. Samples are
  // noted before results are checked, although a result can never belong to a
  // sample accepted on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) board.note_sample(in_bus.channel, in_bus.sample);
      if (out_bus.valid && out_bus.ready) board.check_mean(out_bus.mean_square);
      if (cfg_bus.valid && cfg_bus.ready) board.write_reg(cfg_bus.index, cfg_bus.data);
    end
  end

  // Presents one sample and returns on the edge that accepts it. Random idle
  // cycles go in front of the beat unless the run is calm; valid stays high
  // between back-to-back beats.
  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    while (!calm && $urandom_range(99) < 15) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.channel <= ch;
    in_bus.sample  <= smp;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic stop_samples();
    in_bus.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // Rewrites all three registers once the core has gone quiet. The bits above
  // each register's width carry noise, which the core must drop. Optionally a
  // write to the undecoded index is slipped in between.
  task automatic configure(input logic [CFG_DATA_W-1:0] chans,
                           input logic [CFG_DATA_W-1:0] sweeps,
                           input logic [CFG_DATA_W-1:0] inv,
                           input bit poke_unused);
    logic [CFG_DATA_W-1:0] noise;
    settle();
    noise = $urandom;
    cfg_beat(CFG_CHANNELS, {noise[CFG_DATA_W-1:NCH_W], chans[NCH_W-1:0]});
    if (poke_unused) cfg_beat(CFG_UNUSED, $urandom);
    cfg_beat(CFG_SWEEPS, {noise[CFG_DATA_W-1:SWEEP_W], sweeps[SWEEP_W-1:0]});
    cfg_beat(CFG_INVERSE, inv);
    cfg_bus.valid <= 1'b0;
  endtask

  // Full-scale values, zero and minus one show up often. Loud phases lean on
  // large magnitudes so that window sums grow past the Q8.24 range.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input bit loud);
    int unsigned         roll;
    logic [SAMPLE_W-1:0] mag;
    roll = $urandom_range(99);
    mag  = SAMPLE_W'($urandom_range(32767, 24576));
    if (roll < 8) return MOST_NEGATIVE;
    else if (roll < 16) return MOST_POSITIVE;
    else if (roll < 20) return '0;
    else if (roll < 24) return '1;
    else if (loud || roll < 40) return $urandom_range(1) ? -mag : mag;
    return SAMPLE_W'($urandom);
  endfunction

  // Mostly well-formed sweeps over the active channels with random samples;
  // about one beat in ten hits a random channel without moving the sweep.
  // Halfway through, and now and then at random, the sender holds off until
  // every outstanding result has come back.
  task automatic run_phase(input int items, input logic [NCH_W-1:0] chans, input bit loud);
    int unsigned       lanes;
    int unsigned       sweep_pos;
    logic [CHAN_W-1:0] ch;
    lanes     = (chans == 0) ? 1 : chans;
    sweep_pos = 0;
    for (int k = 0; k < items; k++) begin
      if (k == items / 2 || $urandom_range(199) == 0) begin
        stop_samples();
        wait_for_results();
      end
      if ($urandom_range(9) == 0) begin
        ch = CHAN_W'($urandom_range(255));
      end else begin
        ch = CHAN_W'(sweep_pos);
        sweep_pos = (sweep_pos + 1) % lanes;
      end
      send_sample(ch, pick_sample(loud));
    end
  endtask

  initial begin
    board = new();
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.channel <= '0;
    in_bus.sample  <= '0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= CFG_CHANNELS;
    cfg_bus.data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a 1000-sweep window over 256 channels never closes here,
    // so every beat must return the reset mean of 1.0.
    send_sample(8'd0, MOST_POSITIVE);
    send_sample(8'd255, MOST_NEGATIVE);
    send_sample(8'd128, '0);
    send_sample(8'd1, '1);
    send_sample(8'd2, 16'h0001);
    stop_samples();

    // Zero channel count and zero window both act as one, so every call
    // closes a one-call window. Full-scale inverse; the undecoded index is
    // written in between and must be ignored.
    configure(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
    repeat (4) send_sample(8'd3, MOST_NEGATIVE);
    send_sample(8'd200, 16'h5A5A);
    stop_samples();

    // Channel count above the channel store, taken as given.
    configure(32'd511, 32'd2, 32'h8000_0000, 1'b0);
    for (int k = 0; k < 6; k++) send_sample(CHAN_W'(k * 97), pick_sample(1'b0));
    stop_samples();

    // Random phases over a spread of settings, extremes among them.
    configure(32'd4, 32'd3, 32'd1431655765, 1'b0);
    run_phase(70, 9'd4, 1'b0);
    stop_samples();
    configure(32'd1, 32'd8, 32'hFFFF_FFFF, 1'b0);
    run_phase(50, 9'd1, 1'b1);
    stop_samples();
    configure(32'd256, 32'd1, $urandom, 1'b0);
    run_phase(270, 9'd256, 1'b0);
    stop_samples();
    calm = 1'b1;
    configure(32'd3, 32'd5, 32'd858993459, 1'b0);
    run_phase(60, 9'd3, 1'b1);
    stop_samples();
    calm = 1'b0;
    configure(32'd7, 32'd2, 32'h8000_0000, 1'b0);
    run_phase(50, 9'd7, 1'b0);
    stop_samples();
    configure(32'd300, 32'd1, $urandom, 1'b0);
    run_phase(40, 9'd300, 1'b0);
    stop_samples();
    configure(32'd5, 32'd4, 32'd0, 1'b0);
    run_phase(40, 9'd5, 1'b1);
    stop_samples();
    configure(32'd2, 32'd65535, $urandom, 1'b1);
    run_phase(20, 9'd2, 1'b0);
    stop_samples();

    // One-call windows with the smallest inverse, so that the rounding of
    // small sums decides the stored means.
    configure(32'd1, 32'd1, 32'd1, 1'b0);
    send_sample(8'd5, '0);
    send_sample(8'd6, MOST_POSITIVE);
    send_sample(8'd5, 16'h0001);
    stop_samples();

    settle();
    if (board.failures == 0 && board.outstanding() == 0) begin
      $display("per_channel_mean_square_window_core_tb: PASS");
    end else begin
      $display("per_channel_mean_square_window_core_tb: FAIL");
    end
    $finish;
  end

  // The slowest correct run is under 0.2 ms of simulated time; this is several times that.
  initial begin
    #2000000;
    $display("per_channel_mean_square_window_core_tb: FAIL");
    $finish;
  end

endmodule
